### src/pmlr_pkg.sv
// Shared types and codes for the paged MMU with LFU replacement.
package pmlr_pkg;
    localparam int PAGES = 32;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_EXEC   = 3'd2;
    localparam logic [2:0] OP_UNDEF  = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;
    localparam logic [2:0] OP_UNDEF5 = 3'd5;
    localparam logic [2:0] OP_UNDEF6 = 3'd6;
    localparam logic [2:0] OP_UNDEF7 = 3'd7;

    localparam logic [1:0] KIND_ACCESS   = 2'd0;
    localparam logic [1:0] KIND_PAGE_OUT = 2'd1;
    localparam logic [1:0] KIND_PAGE_IN  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BOUNDS   = 3'd1;
    localparam logic [2:0] ST_OWNER    = 3'd2;
    localparam logic [2:0] ST_RD_DENY  = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [9:0] vaddr;
        logic [1:0] requester;
        logic [7:0] wdata;
        logic [2:0] prot_bits;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] status;
        logic [4:0] page_no;
        logic [1:0] frame_no;
        logic [4:0] paddr;
        logic       rd_en;
        logic       wr_en;
        logic [7:0] wr_byte;
        logic       last;
    } t_rsp;
endpackage

### src/pmlr_if.sv
// Valid/ready channel interfaces for request and response words.
interface pmlr_req_if;
    logic            valid;
    logic            ready;
    pmlr_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pmlr_rsp_if;
    logic            valid;
    logic            ready;
    pmlr_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/pmlr_ram.sv
// Generic single-port RAM with registered read.
module pmlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### src/paged_mmu_lfu_replacement_top.sv
// Top level of the paged MMU with LFU page replacement.
//
// i_req carries one request word: op, vaddr, requester, wdata, prot_bits.
// o_rsp carries one to three response words per request; the final one has
// last set. A miss may give a page-out word, then always a page-in word,
// then the access result.
// The page table sits in one 32-entry RAM (resident, dirty, frame, count,
// protection, owner) with a registered read; frame occupancy is in
// flip-flops. One request is handled at a time. A miss with all frames
// busy scans all 32 entries through the RAM port one per cycle. The next
// request word is accepted in the cycle the final word appears.
// Reset clears the per-entry valid bits and the frame flags; an entry whose
// valid bit is clear reads as all zero, so no clearing pass is needed.
// A stalled receiver holds the response register, and the block waits.
module paged_mmu_lfu_replacement_top (
    input  logic i_clk,
    input  logic i_rst_n,
    pmlr_req_if.sink   i_req,
    pmlr_rsp_if.source o_rsp
);
    localparam int PAGES = pmlr_pkg::PAGES;
    localparam int PW = $clog2(PAGES);
    localparam int EW = 1 + 1 + 2 + 16 + 3 + 2;
    localparam logic [15:0] CMAX = 16'hFFFF;

    typedef struct packed {
        logic        res;
        logic        dty;
        logic [1:0]  frm;
        logic [15:0] cnt;
        logic [2:0]  prot;
        logic [1:0]  own;
    } t_ent;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_SCAN, S_SCAN_END, S_EVICT, S_PGIN, S_RD2, S_ACC, S_OUT
    } t_state;

    t_state           r_state, n_state;
    pmlr_pkg::t_req   r_req, n_req;
    logic [PAGES-1:0] r_vld, n_vld;
    logic [3:0]       r_busy, n_busy;
    logic [PW-1:0]    r_addr, n_addr;
    logic [PW:0]      r_scan, n_scan;
    logic             r_have, n_have;
    logic [15:0]      r_best, n_best;
    logic [PW-1:0]    r_vic, n_vic;
    logic [1:0]       r_vfrm, n_vfrm;
    logic             r_vdty, n_vdty;
    logic [1:0]       r_fr, n_fr;
    logic             r_fin, n_fin;
    logic             r_rvld, n_rvld;
    pmlr_pkg::t_rsp   r_rsp, n_rsp;
    logic             r_we, n_we;
    t_ent             r_wd, n_wd;
    logic             r_rdv, n_rdv;
    t_ent             rd_raw;
    t_ent             ent;
    t_ent             acc_ent;
    logic [1:0]       acc_fr;
    logic [2:0]       acc_st;
    logic             acc_rd;
    logic             acc_wr;
    logic [PW-1:0]    page;
    logic [2:0]       off;
    logic             slot_free;
    logic             free_any;
    logic [1:0]       free_fr;

    pmlr_ram #(.WIDTH(EW), .DEPTH(PAGES)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_addr (r_addr),
        .i_wdata(r_wd),
        .o_rdata(rd_raw)
    );

    always_comb begin
        ent = r_rdv ? rd_raw : '0;
        page = r_req.vaddr[PW+2:3];
        off  = r_req.vaddr[2:0];
        slot_free = !r_rvld || o_rsp.ready;
        free_any = 1'b0;
        free_fr  = 2'd0;
        for (int f = 3; f >= 0; f--) begin
            if (!r_busy[f]) begin
                free_any = 1'b1;
                free_fr  = 2'(f);
            end
        end
    end

    always_comb begin
        acc_fr  = r_fin ? r_fr : ent.frm;
        acc_ent = ent;
        if (r_fin) begin
            acc_ent.res = 1'b1;
            acc_ent.dty = 1'b0;
            acc_ent.frm = r_fr;
            acc_ent.cnt = '0;
        end
        acc_rd = 1'b0;
        acc_wr = 1'b0;
        acc_st = pmlr_pkg::ST_OK;
        if (acc_ent.own != r_req.requester) begin
            acc_st = pmlr_pkg::ST_OWNER;
        end else if (r_req.op <= pmlr_pkg::OP_EXEC) begin
            if (acc_ent.cnt != CMAX) begin
                acc_ent.cnt = acc_ent.cnt + 16'd1;
            end
            if (!acc_ent.prot[r_req.op[1:0]]) begin
                acc_st = pmlr_pkg::ST_RD_DENY + r_req.op;
            end else begin
                acc_rd = (r_req.op == pmlr_pkg::OP_READ);
                acc_wr = (r_req.op == pmlr_pkg::OP_WRITE);
                if (acc_wr) begin
                    acc_ent.dty = 1'b1;
                end
            end
        end else begin
            acc_st = pmlr_pkg::ST_INVALID;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rvld;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_vld   = r_vld;
        n_busy  = r_busy;
        n_addr  = r_addr;
        n_scan  = r_scan;
        n_have  = r_have;
        n_best  = r_best;
        n_vic   = r_vic;
        n_vfrm  = r_vfrm;
        n_vdty  = r_vdty;
        n_fr    = r_fr;
        n_fin   = r_fin;
        n_rvld  = r_rvld;
        n_rsp   = r_rsp;
        n_we    = 1'b0;
        n_wd    = r_wd;
        n_rdv   = r_vld[r_addr];
        if (o_rsp.ready) begin
            n_rvld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_addr  = i_req.data.vaddr[PW+2:3];
                    n_fin   = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (slot_free) begin
                    if (r_req.vaddr >= 10'(PAGES * 8)) begin
                        n_rsp   = '{kind: pmlr_pkg::KIND_ACCESS,
                                    status: pmlr_pkg::ST_BOUNDS, last: 1'b1,
                                    default: '0};
                        n_rvld  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_req.op == pmlr_pkg::OP_LOAD) begin
                        n_wd = '{res: ent.res, dty: ent.dty, frm: ent.frm,
                                 cnt: ent.cnt, prot: r_req.prot_bits,
                                 own: r_req.requester};
                        n_we = 1'b1;
                        n_vld[page] = 1'b1;
                        n_rsp = '{kind: pmlr_pkg::KIND_ACCESS,
                                  status: pmlr_pkg::ST_OK, page_no: 5'(page),
                                  last: 1'b1, default: '0};
                        n_rvld  = 1'b1;
                        n_state = S_IDLE;
                    end else if (ent.res || r_fin) begin
                        n_state = S_ACC;
                    end else if (free_any) begin
                        n_fr    = free_fr;
                        n_state = S_PGIN;
                    end else begin
                        n_scan  = '0;
                        n_addr  = '0;
                        n_have  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan != '0 && ent.res && (!r_have || ent.cnt < r_best)) begin
                    n_have = 1'b1;
                    n_best = ent.cnt;
                    n_vic  = r_addr - PW'(1);
                    n_vfrm = ent.frm;
                    n_vdty = ent.dty;
                end
                n_scan = r_scan + (PW+1)'(1);
                n_addr = r_addr + PW'(1);
                if (r_scan == (PW+1)'(PAGES - 1)) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                if (ent.res && (!r_have || ent.cnt < r_best)) begin
                    n_have = 1'b1;
                    n_vic  = PW'(PAGES - 1);
                    n_vfrm = ent.frm;
                    n_vdty = ent.dty;
                end
                n_state = S_EVICT;
            end
            S_EVICT: begin
                if (slot_free) begin
                    if (r_have) begin
                        n_fr = r_vfrm;
                        if (r_vdty) begin
                            n_rsp = '{kind: pmlr_pkg::KIND_PAGE_OUT,
                                      status: pmlr_pkg::ST_OK,
                                      page_no: 5'(r_vic), frame_no: r_vfrm,
                                      default: '0};
                            n_rvld = 1'b1;
                        end
                    end else begin
                        n_fr = 2'd0;
                    end
                    n_addr  = r_vic;
                    n_state = S_RD2;
                end
            end
            S_RD2: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_have) begin
                    n_wd = '{res: 1'b0, dty: 1'b0, frm: ent.frm, cnt: '0,
                             prot: ent.prot, own: ent.own};
                    n_we = 1'b1;
                end
                n_state = S_PGIN;
            end
            S_PGIN: begin
                if (!r_we && (r_addr == page) && slot_free) begin
                    n_busy[r_fr] = 1'b1;
                    n_rsp = '{kind: pmlr_pkg::KIND_PAGE_IN,
                              status: pmlr_pkg::ST_OK, page_no: 5'(page),
                              frame_no: r_fr, default: '0};
                    n_rvld  = 1'b1;
                    n_addr  = page;
                    n_state = S_RD;
                    n_fin   = 1'b1;
                end else if (!r_we) begin
                    n_addr = page;
                end
            end
            S_ACC: begin
                if (slot_free) begin
                    n_wd  = acc_ent;
                    n_we  = 1'b1;
                    n_vld[page] = 1'b1;
                    n_fin = 1'b0;
                    n_rsp = '{kind: pmlr_pkg::KIND_ACCESS, status: acc_st,
                              page_no: 5'(page), frame_no: acc_fr,
                              paddr: {acc_fr, off}, rd_en: acc_rd, wr_en: acc_wr,
                              wr_byte: acc_wr ? r_req.wdata : 8'd0, last: 1'b1};
                    n_rvld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_busy  <= '0;
            r_rvld  <= 1'b0;
            r_we    <= 1'b0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            r_vld   <= n_vld;
            r_busy  <= n_busy;
            r_addr  <= n_addr;
            r_scan  <= n_scan;
            r_have  <= n_have;
            r_best  <= n_best;
            r_vic   <= n_vic;
            r_vfrm  <= n_vfrm;
            r_vdty  <= n_vdty;
            r_fr    <= n_fr;
            r_fin   <= n_fin;
            r_rvld  <= n_rvld;
            r_rsp   <= n_rsp;
            r_we    <= n_we;
            r_wd    <= n_wd;
            r_rdv   <= n_rdv;
        end
    end
endmodule
